// ----- rtl/core/isp_pkg.sv -----
// Shared constants, types and helpers for the interval subscription matcher.
// No dependencies.
package isp_pkg;

  localparam int SUB_W  = 10;
  localparam int ATTR_W = 4;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 11;

  // Cells in the chain; slot s lives in cell s % NUM_CELLS.
  localparam int NUM_CELLS = 16;
  localparam int CELL_W    = 4;

  localparam int              NUM_SUBS_DEF     = 1024;
  localparam int              NUM_ATTRS_DEF    = 16;
  localparam longint unsigned VALUE_DOMAIN_DEF = 64'd65536;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_ADD   = 3'd1,
    OP_PAIR  = 3'd2,
    OP_FINAL = 3'd3
  } cell_op_e;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_e op;
    logic     issue;   // read the addressed entry this cycle
    logic     start;   // clear the per-cell match count
  } cell_cmd_t;

endpackage

// ----- rtl/core/isp_cell.sv -----
// One cell of the matcher chain: bound store, per-slot mask/fail word and a
// stage of the match-count sum chain. Depends on isp_pkg.
module isp_cell #(
  parameter int CELL_ID   = 0,
  parameter int NUM_SUBS  = isp_pkg::NUM_SUBS_DEF,
  parameter int NUM_ATTRS = isp_pkg::NUM_ATTRS_DEF,
  parameter int LW        = 6,
  parameter int SUM_W     = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  isp_pkg::cell_cmd_t            cmd_i,
  input  logic                          sel_i,
  input  logic [LW-1:0]                 addr_i,
  input  logic [isp_pkg::ATTR_W-1:0]    attr_i,
  input  logic [isp_pkg::VAL_W-1:0]     low_i,
  input  logic [isp_pkg::VAL_W-1:0]     high_i,
  input  logic [isp_pkg::VAL_W-1:0]     val_i,
  input  logic [NUM_ATTRS-1:0]          present_i,
  input  logic [SUM_W-1:0]              sum_i,
  output logic [SUM_W-1:0]              sum_o
);
  import isp_pkg::*;

  localparam int DEPTH  = 2 ** LW;
  localparam int BDEPTH = 2 ** (LW + ATTR_W);
  localparam int WW     = NUM_ATTRS + 1;   // {fail, constrained mask}

  logic [WW-1:0]        word_mem [DEPTH];
  logic [2*VAL_W-1:0]   bnd_mem  [BDEPTH];

  logic [WW-1:0]        word_rd_q;
  logic [2*VAL_W-1:0]   bnd_rd_q;
  logic                 v_q;
  cell_op_e             op_q;
  logic                 sel_q;
  logic [LW-1:0]        a_q;
  logic [LW:0]          cnt_q, cnt_d;
  logic [SUM_W-1:0]     sum_q;

  logic [NUM_ATTRS-1:0] attr_oh, mask;
  logic                 fail, hit, outside, failed, in_range;
  logic                 word_we, bnd_we;
  logic [WW-1:0]        word_wd;
  logic [VAL_W-1:0]     bnd_lo, bnd_hi;
  logic [LW+CELL_W-1:0] gidx;

  assign attr_oh  = NUM_ATTRS'(1) << attr_i;
  assign mask     = word_rd_q[NUM_ATTRS-1:0];
  assign fail     = word_rd_q[NUM_ATTRS];
  assign bnd_lo   = bnd_rd_q[2*VAL_W-1:VAL_W];
  assign bnd_hi   = bnd_rd_q[VAL_W-1:0];
  assign hit      = |(mask & attr_oh);
  assign outside  = (bnd_lo > val_i) || (bnd_hi < val_i);
  assign failed   = fail || (|(mask & ~present_i));
  assign gidx     = {a_q, CELL_W'(CELL_ID)};
  assign in_range = (32'(gidx) < 32'(NUM_SUBS));

  always_comb begin
    word_we = 1'b0;
    bnd_we  = 1'b0;
    word_wd = word_rd_q;
    cnt_d   = cnt_q;
    if (cmd_i.start) cnt_d = '0;
    if (v_q) begin
      case (op_q)
        OP_CLEAR: begin
          word_we = 1'b1;
          word_wd = '0;
        end
        OP_ADD: begin
          word_we = sel_q;
          bnd_we  = sel_q;
          word_wd = {fail, mask | attr_oh};
        end
        OP_PAIR: begin
          word_we = 1'b1;
          word_wd = {fail | (hit & outside), mask};
        end
        OP_FINAL: begin
          word_we = 1'b1;
          word_wd = {1'b0, mask};
          if (!failed && in_range) cnt_d = cnt_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      word_rd_q <= word_mem[addr_i];
      bnd_rd_q  <= bnd_mem[{addr_i, attr_i}];
    end
    if (word_we) word_mem[a_q] <= word_wd;
    if (bnd_we)  bnd_mem[{a_q, attr_i}] <= {low_i, high_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      op_q  <= OP_CLEAR;
      sel_q <= 1'b0;
      a_q   <= '0;
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      v_q   <= cmd_i.issue;
      op_q  <= cmd_i.op;
      sel_q <= sel_i;
      a_q   <= addr_i;
      cnt_q <= cnt_d;
      sum_q <= sum_i + SUM_W'(cnt_q);
    end
  end

  assign sum_o = sum_q;

endmodule

// ----- rtl/core/interval_subscription_matcher.sv -----
// Top level of the interval subscription matcher: input register, sequencer
// and the chain of isp_cell instances. Depends on isp_pkg and isp_cell.
//
// Usage. One input channel (in_valid_i/in_ready_o) carries both constraint
// adds (func_i = 0) and publication pairs (func_i = 1). One output channel
// (out_valid_o/out_ready_i) returns match_count_o once per publication, on the
// transaction marked last_pair_i.
// Slots are spread over 16 cells (slot s in cell s % 16). Each cell holds the
// bounds and a {fail, constrained-attribute} word per local slot in memories
// with one read and one write port, and sweeps its local slots one per cycle.
// Steps, from one accepted transaction to the next accept, with
// S = 2**ceil(log2(NUM_SUBS/16)) local slots (64 by default):
//   add            : accept, then read-modify-write of the slot word
//   pair           : accept, then a sweep over the S local slots, paced by the per-cell memory port
//   last pair      : accept, pair sweep (skipped for an invalid attribute), end sweep,
//                    the sum ripples through the 16-stage count
//                    chain, then the output register is loaded
//   ignored items  : accepted and dropped in the idle state
// Only one transaction is in flight; in_ready_o is high in the idle state.
// After reset the block sweeps all S local slots clearing the slot words and accepts
// nothing meanwhile. A waiting result sits in the output register; new input
// is taken while it waits, and only a following result stalls behind it.
module interval_subscription_matcher #(
  parameter int              NUM_SUBS     = isp_pkg::NUM_SUBS_DEF,
  parameter int              NUM_ATTRS    = isp_pkg::NUM_ATTRS_DEF,
  parameter longint unsigned VALUE_DOMAIN = isp_pkg::VALUE_DOMAIN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [isp_pkg::SUB_W-1:0]    sub_id_i,
  input  logic [isp_pkg::ATTR_W-1:0]   attribute_i,
  input  logic [isp_pkg::VAL_W-1:0]    low_value_i,
  input  logic [isp_pkg::VAL_W-1:0]    high_value_i,
  input  logic [isp_pkg::VAL_W-1:0]    pub_value_i,
  input  logic                         last_pair_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [isp_pkg::CNT_W-1:0]    match_count_o
);
  import isp_pkg::*;

  localparam int SPC   = (NUM_SUBS + NUM_CELLS - 1) / NUM_CELLS;
  localparam int LW    = (SPC > 1) ? $clog2(SPC) : 1;
  localparam int SW    = LW + 1;
  localparam int SUM_W = ($clog2(NUM_SUBS + 1) > CNT_W) ? $clog2(NUM_SUBS + 1) : CNT_W;
  localparam int SUM_WAIT = NUM_CELLS + 2;
  localparam logic [VAL_W-1:0] VTOP =
    (VALUE_DOMAIN > 64'd65536) ? {VAL_W{1'b1}} : VAL_W'(VALUE_DOMAIN - 64'd1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_ADD   = 7'b0000100,
    S_PAIR  = 7'b0001000,
    S_FINAL = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic [SW-1:0]          cnt_q, cnt_d;
  logic [CELL_W:0]        wait_q, wait_d;
  logic [NUM_ATTRS-1:0]   present_q, present_d;
  logic                   last_q;
  logic [SUB_W-1:0]       sub_q;
  logic [ATTR_W-1:0]      attr_q;
  logic [VAL_W-1:0]       lo_q, hi_q, val_q;
  logic                   out_valid_q;
  logic [CNT_W-1:0]       count_q;

  logic                   in_fire, tail, attr_ok, sub_ok;
  logic [LW-1:0]          loc_addr, addr;
  cell_cmd_t              cmd;
  logic [SUM_W-1:0]       chain [NUM_CELLS+1];
  logic [SUM_W-1:0]       total;

  function automatic logic [VAL_W-1:0] clamp(input logic [VAL_W-1:0] v);
    clamp = (v > VTOP) ? VTOP : v;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign tail       = cnt_q[LW];
  assign attr_ok    = (32'(attribute_i) < 32'(NUM_ATTRS));
  assign sub_ok     = (32'(sub_id_i) < 32'(NUM_SUBS));
  assign loc_addr   = LW'(16'(sub_q) >> CELL_W);
  assign addr       = (state_q == S_ADD) ? loc_addr : cnt_q[LW-1:0];

  // Sequencer: sweeps drive the cells in lock step.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    wait_d    = wait_q;
    present_d = present_q;
    cmd.op    = OP_CLEAR;
    cmd.issue = 1'b0;
    cmd.start = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd.op    = OP_CLEAR;
        cmd.issue = !tail;
        cnt_d     = cnt_q + 1'b1;
        if (tail) state_d = S_IDLE;
      end
      S_IDLE: begin
        cnt_d = '0;
        if (in_fire) begin
          if (!func_i) begin
            if (sub_ok && attr_ok) state_d = S_ADD;
          end else if (attr_ok) begin
            present_d = present_q | (NUM_ATTRS'(1) << attribute_i);
            state_d   = S_PAIR;
          end else if (last_pair_i) begin
            state_d = S_FINAL;
          end
        end
      end
      S_ADD: begin
        cmd.op    = OP_ADD;
        cmd.issue = (cnt_q == '0);
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q != '0) state_d = S_IDLE;
      end
      S_PAIR: begin
        cmd.op    = OP_PAIR;
        cmd.issue = !tail;
        cnt_d     = cnt_q + 1'b1;
        if (tail) begin
          cnt_d   = '0;
          state_d = last_q ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        cmd.op    = OP_FINAL;
        cmd.issue = !tail;
        cmd.start = (cnt_q == '0);
        cnt_d     = cnt_q + 1'b1;
        if (tail) begin
          present_d = '0;
          wait_d    = '0;
          state_d   = S_SUM;
        end
      end
      S_SUM: begin
        wait_d = wait_q + 1'b1;
        if (32'(wait_q) == SUM_WAIT) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      wait_q      <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      wait_q    <= wait_d;
      present_q <= present_d;
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Transaction payload, held for the whole sweep.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      last_q <= last_pair_i;
      sub_q  <= sub_id_i;
      attr_q <= attribute_i;
      lo_q   <= clamp(low_value_i);
      hi_q   <= clamp(high_value_i);
      val_q  <= clamp(pub_value_i);
    end
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      count_q <= (total > SUM_W'(11'h7FF)) ? 11'h7FF : total[CNT_W-1:0];
    end
  end

  assign chain[0] = '0;
  assign total    = chain[NUM_CELLS];

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    isp_cell #(
      .CELL_ID   (c),
      .NUM_SUBS  (NUM_SUBS),
      .NUM_ATTRS (NUM_ATTRS),
      .LW        (LW),
      .SUM_W     (SUM_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .sel_i     (sub_q[CELL_W-1:0] == CELL_W'(c)),
      .addr_i    (addr),
      .attr_i    (attr_q),
      .low_i     (lo_q),
      .high_i    (hi_q),
      .val_i     (val_q),
      .present_i (present_q),
      .sum_i     (chain[c]),
      .sum_o     (chain[c+1])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign match_count_o = count_q;

  a_pair_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAIR && tail) |=> (state_q == S_FINAL || state_q == S_IDLE))
    else $error("pair sweep left to a wrong state");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_OUT)
    else $error("result raised outside output state");

  a_present_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL && tail) |=> (present_q == '0))
    else $error("presence mask not cleared after publication");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> (32'(total) <= 32'(NUM_SUBS)))
    else $error("match count above slot count");

endmodule
